>>> src/hnp_pkg.sv
`timescale 1ns / 1ps

package hnp_pkg;

	localparam int INDEX_BITS_DEF    = 29;
	localparam int MAX_NEIGHBORS_DEF = 2048;

	localparam int IDX_W    = 29;
	localparam int WORD_W   = 32;
	localparam int COORD_W  = 32;
	localparam int COUNT_W  = 12;
	localparam int TOL_W    = 31;
	localparam int CUT_W    = 62;

	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [2:0] {
		REG_NEWTON_MODE    = 3'd0,
		REG_TRICLINIC_MODE = 3'd1,
		REG_TRIM_ENABLE    = 3'd2,
		REG_LOCAL_COUNT    = 3'd3,
		REG_TOLERANCE      = 3'd4,
		REG_CUTOFF_SQUARED = 3'd5
	} hnp_reg_t;

	localparam logic             NEWTON_MODE_RST    = 1'b1;
	localparam logic             TRICLINIC_MODE_RST = 1'b0;
	localparam logic             TRIM_ENABLE_RST    = 1'b0;
	localparam logic [IDX_W-1:0] LOCAL_COUNT_RST    = '0;
	localparam logic [TOL_W-1:0] TOLERANCE_RST      = 31'd655;
	localparam logic [CUT_W-1:0] CUTOFF_SQUARED_RST = '0;

	typedef struct packed {
		logic             newton_mode;
		logic             triclinic_mode;
		logic             trim_enable;
		logic [IDX_W-1:0] local_count;
		logic [TOL_W-1:0] tolerance;
		logic [CUT_W-1:0] cutoff_squared;
	} hnp_cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]          atom_index;
		logic                      has_neighbor;
		logic [WORD_W-1:0]         neighbor_word;
		logic                      last_neighbor;
		logic signed [COORD_W-1:0] atom_x;
		logic signed [COORD_W-1:0] atom_y;
		logic signed [COORD_W-1:0] atom_z;
		logic signed [COORD_W-1:0] nbr_x;
		logic signed [COORD_W-1:0] nbr_y;
		logic signed [COORD_W-1:0] nbr_z;
	} hnp_in_t;

	typedef struct packed {
		logic               keep;
		logic [WORD_W-1:0]  kept_word;
		logic [IDX_W-1:0]   owner_index;
		logic               atom_done;
		logic [COUNT_W-1:0] kept_count;
		logic [IDX_W-1:0]   atoms_done;
		logic               overflow;
	} hnp_out_t;

endpackage

>>> src/hnp_stream_if.sv
`timescale 1ns / 1ps

interface hnp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/hnp_cfg_regs.sv
`timescale 1ns / 1ps

module hnp_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hnp_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [hnp_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [hnp_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	output hnp_pkg::hnp_cfg_t                cfg
);

	hnp_pkg::hnp_cfg_t cfg_q;
	hnp_pkg::hnp_reg_t reg_sel;
	logic              wr_en;

	assign reg_sel = hnp_pkg::hnp_reg_t'(paddr[5:3]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.newton_mode    <= hnp_pkg::NEWTON_MODE_RST;
			cfg_q.triclinic_mode <= hnp_pkg::TRICLINIC_MODE_RST;
			cfg_q.trim_enable    <= hnp_pkg::TRIM_ENABLE_RST;
			cfg_q.local_count    <= hnp_pkg::LOCAL_COUNT_RST;
			cfg_q.tolerance      <= hnp_pkg::TOLERANCE_RST;
			cfg_q.cutoff_squared <= hnp_pkg::CUTOFF_SQUARED_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				hnp_pkg::REG_NEWTON_MODE:    cfg_q.newton_mode    <= pwdata[0];
				hnp_pkg::REG_TRICLINIC_MODE: cfg_q.triclinic_mode <= pwdata[0];
				hnp_pkg::REG_TRIM_ENABLE:    cfg_q.trim_enable    <= pwdata[0];
				hnp_pkg::REG_LOCAL_COUNT:
					cfg_q.local_count <= pwdata[hnp_pkg::IDX_W-1:0];
				hnp_pkg::REG_TOLERANCE:
					cfg_q.tolerance <= pwdata[hnp_pkg::TOL_W-1:0];
				hnp_pkg::REG_CUTOFF_SQUARED:
					cfg_q.cutoff_squared <= pwdata[hnp_pkg::CUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			hnp_pkg::REG_NEWTON_MODE:    prdata[0] = cfg_q.newton_mode;
			hnp_pkg::REG_TRICLINIC_MODE: prdata[0] = cfg_q.triclinic_mode;
			hnp_pkg::REG_TRIM_ENABLE:    prdata[0] = cfg_q.trim_enable;
			hnp_pkg::REG_LOCAL_COUNT:
				prdata[hnp_pkg::IDX_W-1:0] = cfg_q.local_count;
			hnp_pkg::REG_TOLERANCE:
				prdata[hnp_pkg::TOL_W-1:0] = cfg_q.tolerance;
			hnp_pkg::REG_CUTOFF_SQUARED:
				prdata[hnp_pkg::CUT_W-1:0] = cfg_q.cutoff_squared;
			default: prdata = '0;
		endcase
	end

endmodule

>>> src/half_neighbor_pair_filter.sv
`timescale 1ns / 1ps

// Half neighbor list filter. Pairs of a full neighbor list arrive on in_ch, one
// item per pair, plus closing items with has_neighbor low for atoms that have
// no neighbors. Every input item yields exactly one result item on out_ch,
// carrying the keep decision, the raw neighbor word, the running kept count of
// the owner atom, the count of closed atoms and the sticky overflow flag.
// The APB port sets the mode, local atom count, tolerance and trim cutoff; the
// user must write it only while no items are in flight (not enforced here).
// The pipeline has an input register, a decision stage, a multiplier stage
// for the three squared distances and an output register. One item is taken
// every cycle while the receiver does not stall; the throughput is set by the
// single pass through these stages.
// When the receiver stalls, the output register holds its item and each
// stage behind it fills in turn; in_ch.ready falls only once all stages are
// full. Reset clears the stage valid bits, the counters and the overflow
// flag, and loads the register defaults.
module half_neighbor_pair_filter #(
	parameter int INDEX_BITS    = hnp_pkg::INDEX_BITS_DEF,
	parameter int MAX_NEIGHBORS = hnp_pkg::MAX_NEIGHBORS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	hnp_stream_if.sink                      in_ch,
	hnp_stream_if.source                    out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hnp_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [hnp_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [hnp_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);
	localparam logic [hnp_pkg::COUNT_W-1:0] MAX_CNT = hnp_pkg::COUNT_W'(MAX_NEIGHBORS);

	function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			return d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return d[31:0];
	endfunction

	function automatic logic [31:0] magn(input logic signed [31:0] d);
		return d[31] ? (~d + 32'd1) : d;
	endfunction

	hnp_pkg::hnp_cfg_t cfg;

	hnp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake chain.
	logic v1_s1, v2_s2, v3_s3, out_v_q;
	logic rdy_o, rdy3, rdy2, rdy1;

	assign rdy_o       = !out_v_q || out_ch.ready;
	assign rdy3        = !v3_s3 || rdy_o;
	assign rdy2        = !v2_s2 || rdy3;
	assign rdy1        = !v1_s1 || rdy2;
	assign in_ch.ready = rdy1;

	// Stage 1: input register.
	hnp_pkg::hnp_in_t d_s1;

	// Stage 1 decision logic.
	logic [31:0]        j_ext, i_ext, lc_ext;
	logic [31:0]        tmag_y, tmag_z;
	logic               keep_pre;
	logic signed [31:0] ax, ay, az, bx, by, bz;

	always_comb begin
		ax     = $signed(d_s1.atom_x);
		ay     = $signed(d_s1.atom_y);
		az     = $signed(d_s1.atom_z);
		bx     = $signed(d_s1.nbr_x);
		by     = $signed(d_s1.nbr_y);
		bz     = $signed(d_s1.nbr_z);
		j_ext  = d_s1.neighbor_word & IDX_MASK;
		i_ext  = {3'd0, d_s1.atom_index};
		lc_ext = {3'd0, cfg.local_count};
		tmag_z = magn(sat_diff(bz, az));
		tmag_y = magn(sat_diff(by, ay));
		keep_pre = 1'b0;
		if (d_s1.has_neighbor) begin
			if (cfg.newton_mode) begin
				if (j_ext < lc_ext) begin
					keep_pre = i_ext <= j_ext;
				end else if (cfg.triclinic_mode) begin
					if (tmag_z > {1'b0, cfg.tolerance}) begin
						keep_pre = bz >= az;
					end else if (tmag_y > {1'b0, cfg.tolerance}) begin
						keep_pre = by >= ay;
					end else begin
						keep_pre = bx >= ax;
					end
				end else begin
					if (bz != az) begin
						keep_pre = bz > az;
					end else if (by != ay) begin
						keep_pre = by > ay;
					end else begin
						keep_pre = bx >= ax;
					end
				end
			end else begin
				keep_pre = j_ext > i_ext;
			end
		end
	end

	// Stage 2: decision and distance magnitudes.
	logic                        keep_s2, done_s2;
	logic [hnp_pkg::WORD_W-1:0]  word_s2;
	logic [hnp_pkg::IDX_W-1:0]   idx_s2;
	logic [31:0]                 mx_s2, my_s2, mz_s2;

	// Stage 3: squares.
	logic                        keep_s3, done_s3;
	logic [hnp_pkg::WORD_W-1:0]  word_s3;
	logic [hnp_pkg::IDX_W-1:0]   idx_s3;
	logic [63:0]                 sqx_s3, sqy_s3, sqz_s3;

	// Stage 3 trim and bookkeeping.
	logic [63:0]                 rsq;
	logic                        keep_fin, adv3;
	logic [hnp_pkg::COUNT_W-1:0] running_q, running_nxt;
	logic [hnp_pkg::IDX_W-1:0]   closed_q, closed_nxt;
	logic                        overflow_q, overflow_nxt;
	hnp_pkg::hnp_out_t           out_d_q;

	assign adv3 = v3_s3 && rdy_o;

	always_comb begin
		rsq      = sqx_s3 + sqy_s3 + sqz_s3;
		keep_fin = keep_s3 && !(cfg.trim_enable && (rsq > {2'b00, cfg.cutoff_squared}));
		running_nxt  = running_q;
		overflow_nxt = overflow_q;
		if (keep_fin) begin
			if (running_q >= MAX_CNT) begin
				overflow_nxt = 1'b1;
			end else begin
				running_nxt = running_q + 1'b1;
			end
		end
		closed_nxt = closed_q + hnp_pkg::IDX_W'(done_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1      <= 1'b0;
			v2_s2      <= 1'b0;
			v3_s3      <= 1'b0;
			out_v_q    <= 1'b0;
			running_q  <= '0;
			closed_q   <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= in_ch.valid;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
			if (rdy_o) begin
				out_v_q <= v3_s3;
			end
			if (adv3) begin
				running_q  <= done_s3 ? '0 : running_nxt;
				closed_q   <= closed_nxt;
				overflow_q <= overflow_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && rdy1) begin
			d_s1 <= in_ch.data;
		end
		if (v1_s1 && rdy2) begin
			keep_s2 <= keep_pre;
			done_s2 <= !d_s1.has_neighbor || d_s1.last_neighbor;
			word_s2 <= d_s1.has_neighbor ? d_s1.neighbor_word : '0;
			idx_s2  <= d_s1.atom_index;
			mx_s2   <= magn(sat_diff(ax, bx));
			my_s2   <= magn(sat_diff(ay, by));
			mz_s2   <= magn(sat_diff(az, bz));
		end
		if (v2_s2 && rdy3) begin
			keep_s3 <= keep_s2;
			done_s3 <= done_s2;
			word_s3 <= word_s2;
			idx_s3  <= idx_s2;
			sqx_s3  <= mx_s2 * mx_s2;
			sqy_s3  <= my_s2 * my_s2;
			sqz_s3  <= mz_s2 * mz_s2;
		end
		if (adv3) begin
			out_d_q.keep        <= keep_fin;
			out_d_q.kept_word   <= word_s3;
			out_d_q.owner_index <= idx_s3;
			out_d_q.atom_done   <= done_s3;
			out_d_q.kept_count  <= running_nxt;
			out_d_q.atoms_done  <= closed_nxt;
			out_d_q.overflow    <= overflow_nxt;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_d_q;

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared after being set");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.data.kept_count <= MAX_CNT))
		else $error("kept count above its limit");

	a_keep_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.keep) |-> (out_ch.data.kept_count != '0))
		else $error("kept item reported with zero count");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv3 && done_s3) |=> (running_q == '0))
		else $error("running count not cleared after atom close");

endmodule

>>> dv/hnp_pair_checker.sv
`timescale 1ns / 1ps

module hnp_pair_checker
	import hnp_pkg::*;
#(
	parameter int INDEX_BITS    = INDEX_BITS_DEF,
	parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hnp_stream_if                 in_ch,
	hnp_stream_if                 out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output int                    mismatches,
	output int                    outstanding
);

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -SAT_HI - 1;

	hnp_cfg_t           cfg;
	logic [COUNT_W-1:0] kept_run;
	logic [IDX_W-1:0]   closed_run;
	logic               ovf_flag;
	hnp_out_t           decisions_due[$];
	int                 errs;

	function automatic longint sat_sub(input longint a, input longint b);
		longint d;
		d = a - b;
		if (d > SAT_HI) d = SAT_HI;
		if (d < SAT_LO) d = SAT_LO;
		return d;
	endfunction

	function automatic longint unsigned magnitude(input longint d);
		return (d < 0) ? -d : d;
	endfunction

	function automatic hnp_out_t decide_pair(input hnp_in_t it);
		hnp_out_t        r;
		longint unsigned iv, jv, rsq;
		longint          ax, ay, az, bx, by, bz;
		logic            keep, done;
		iv = it.atom_index;
		jv = it.neighbor_word & ((64'd1 << INDEX_BITS) - 1);
		ax = $signed(it.atom_x);
		ay = $signed(it.atom_y);
		az = $signed(it.atom_z);
		bx = $signed(it.nbr_x);
		by = $signed(it.nbr_y);
		bz = $signed(it.nbr_z);
		keep = 1'b0;
		done = !it.has_neighbor || it.last_neighbor;
		if (it.has_neighbor) begin
			if (!cfg.newton_mode) begin
				keep = jv > iv;
			end else if (jv < cfg.local_count) begin
				keep = iv <= jv;
			end else if (cfg.triclinic_mode) begin
				if (magnitude(sat_sub(bz, az)) > cfg.tolerance)
					keep = bz >= az;
				else if (magnitude(sat_sub(by, ay)) > cfg.tolerance)
					keep = by >= ay;
				else
					keep = bx >= ax;
			end else begin
				if (bz != az)
					keep = bz > az;
				else if (by != ay)
					keep = by > ay;
				else
					keep = bx >= ax;
			end
			if (keep && cfg.trim_enable) begin
				rsq = magnitude(sat_sub(ax, bx)) * magnitude(sat_sub(ax, bx))
					+ magnitude(sat_sub(ay, by)) * magnitude(sat_sub(ay, by))
					+ magnitude(sat_sub(az, bz)) * magnitude(sat_sub(az, bz));
				if (rsq > cfg.cutoff_squared) keep = 1'b0;
			end
			if (keep) begin
				if (kept_run >= MAX_NEIGHBORS)
					ovf_flag = 1'b1;
				else
					kept_run = kept_run + 1'b1;
			end
		end
		if (done) closed_run = closed_run + 1'b1;
		r.keep        = keep;
		r.kept_word   = it.has_neighbor ? it.neighbor_word : '0;
		r.owner_index = it.atom_index;
		r.atom_done   = done;
		r.kept_count  = kept_run;
		r.atoms_done  = closed_run;
		r.overflow    = ovf_flag;
		if (done) kept_run = '0;
		return r;
	endfunction

	task automatic check_field(input string field, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			errs++;
			if (errs <= 10)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		hnp_out_t want;
		if (!arst_n) begin
			cfg.newton_mode    = NEWTON_MODE_RST;
			cfg.triclinic_mode = TRICLINIC_MODE_RST;
			cfg.trim_enable    = TRIM_ENABLE_RST;
			cfg.local_count    = LOCAL_COUNT_RST;
			cfg.tolerance      = TOLERANCE_RST;
			cfg.cutoff_squared = CUTOFF_SQUARED_RST;
			kept_run   = '0;
			closed_run = '0;
			ovf_flag   = 1'b0;
			decisions_due.delete();
			errs = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (hnp_reg_t'(paddr[CFG_ADDR_W-1:3]))
					REG_NEWTON_MODE:    cfg.newton_mode    = pwdata[0];
					REG_TRICLINIC_MODE: cfg.triclinic_mode = pwdata[0];
					REG_TRIM_ENABLE:    cfg.trim_enable    = pwdata[0];
					REG_LOCAL_COUNT:    cfg.local_count    = pwdata[IDX_W-1:0];
					REG_TOLERANCE:      cfg.tolerance      = pwdata[TOL_W-1:0];
					REG_CUTOFF_SQUARED: cfg.cutoff_squared = pwdata[CUT_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				decisions_due.push_back(decide_pair(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				if (decisions_due.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result item with no pending decision", $time);
				end else begin
					want = decisions_due.pop_front();
					check_field("keep", want.keep, out_ch.data.keep);
					check_field("kept_word", want.kept_word, out_ch.data.kept_word);
					check_field("owner_index", want.owner_index, out_ch.data.owner_index);
					check_field("atom_done", want.atom_done, out_ch.data.atom_done);
					check_field("kept_count", want.kept_count, out_ch.data.kept_count);
					check_field("atoms_done", want.atoms_done, out_ch.data.atoms_done);
					check_field("overflow", want.overflow, out_ch.data.overflow);
				end
			end
			mismatches  <= errs;
			outstanding <= decisions_due.size();
		end
	end

endmodule

>>> dv/tb_half_neighbor_pair_filter.sv
`timescale 1ns / 1ps

module tb_half_neighbor_pair_filter;
	import hnp_pkg::*;

	localparam int                 WATCHDOG_LIMIT   = 4000;
	localparam int                 RANDOM_PHASES    = 8;
	localparam int                 PHASE_ITEMS      = 155;
	localparam logic [COORD_W-1:0] C_MAX            = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] C_MIN            = 32'h8000_0000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel, penable, pwrite, pready;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;
	logic                  sink_ready = 1'b0;
	int                    mismatches, outstanding;
	int                    idle_cycles = 0;
	int                    stall_tick = 0;
	int                    stall_pct = 0;
	int                    burst_left = 1;
	int                    gap_left = 0;
	bit                    in_driving = 1'b0;
	logic [IDX_W-1:0]      cur_lc;
	logic [TOL_W-1:0]      cur_tol;
	logic [IDX_W-1:0]      lc_pick;
	logic [TOL_W-1:0]      tol_pick;
	logic [CUT_W-1:0]      cut_pick;

	hnp_stream_if #(.payload_t(hnp_in_t))  in_if ();
	hnp_stream_if #(.payload_t(hnp_out_t)) out_if ();

	assign out_if.ready = sink_ready;

	half_neighbor_pair_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_if),
		.out_ch  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	hnp_pair_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_if),
		.out_ch      (out_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 256 == 0) begin
			case ($urandom_range(0, 4))
				0, 1: stall_pct <= 0;
				2: stall_pct <= 25;
				3: stall_pct <= 50;
				default: stall_pct <= 85;
			endcase
		end
		sink_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL half_neighbor_pair_filter");
			$finish;
		end
	end

	function automatic hnp_in_t mk(input logic [IDX_W-1:0] i, input logic h,
		input logic [WORD_W-1:0] w, input logic l,
		input logic [COORD_W-1:0] ax, ay, az, bx, by, bz);
		hnp_in_t it;
		it.atom_index    = i;
		it.has_neighbor  = h;
		it.neighbor_word = w;
		it.last_neighbor = l;
		it.atom_x        = ax;
		it.atom_y        = ay;
		it.atom_z        = az;
		it.nbr_x         = bx;
		it.nbr_y         = by;
		it.nbr_z         = bz;
		return it;
	endfunction

	function automatic logic [IDX_W-1:0] pick_owner();
		if ($urandom_range(0, 3) == 0) return IDX_W'($urandom);
		return IDX_W'(32'(cur_lc) + $urandom_range(0, 16) - 8);
	endfunction

	function automatic logic [IDX_W-1:0] pick_neighbor(input logic [IDX_W-1:0] owner);
		case ($urandom_range(0, 3))
			0: return IDX_W'($urandom);
			1: return IDX_W'(32'(cur_lc) + $urandom_range(0, 6) - 3);
			default: return IDX_W'(32'(owner) + $urandom_range(0, 6) - 3);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return '0;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_offset();
		logic [COORD_W-1:0] t;
		t = 32'(cur_tol);
		case ($urandom_range(0, 11))
			0, 1, 2: return '0;
			3: return t;
			4: return -t;
			5: return t + 1;
			6: return -(t + 1);
			7, 8: return $urandom_range(0, 1) ? -$urandom_range(0, 1 << 17)
				: $urandom_range(0, 1 << 17);
			9: return $urandom_range(0, 16) - 8;
			10: return $urandom_range(0, 1) ? -$urandom_range(0, 1 << 24)
				: $urandom_range(0, 1 << 24);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input hnp_in_t it);
		while (gap_left > 0) begin
			@(posedge clk);
			gap_left--;
		end
		in_if.valid <= 1'b1;
		in_if.data  <= it;
		in_driving = 1'b1;
		do @(posedge clk); while (!in_if.ready);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap_left > 0) begin
				in_if.valid <= 1'b0;
				in_driving = 1'b0;
			end
		end
	endtask

	task automatic wait_idle();
		if (in_driving) begin
			in_if.valid <= 1'b0;
			in_driving = 1'b0;
		end
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic cfg_write(input hnp_reg_t r, input logic [CFG_DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic nm, tm, te, input logic [IDX_W-1:0] lc,
		input logic [TOL_W-1:0] tol, input logic [CUT_W-1:0] cut);
		wait_idle();
		cfg_write(REG_NEWTON_MODE, CFG_DATA_W'(nm));
		cfg_write(REG_TRICLINIC_MODE, CFG_DATA_W'(tm));
		cfg_write(REG_TRIM_ENABLE, CFG_DATA_W'(te));
		cfg_write(REG_LOCAL_COUNT, CFG_DATA_W'(lc));
		cfg_write(REG_TOLERANCE, CFG_DATA_W'(tol));
		cfg_write(REG_CUTOFF_SQUARED, CFG_DATA_W'(cut));
		cur_lc  = lc;
		cur_tol = tol;
	endtask

	task automatic random_phase(input int n_items);
		int                 sent, len;
		logic [IDX_W-1:0]   owner, nidx;
		logic [COORD_W-1:0] ax, ay, az;
		bit                 drop_last;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0: begin
					send_item(mk(pick_owner(), 1'b0, $urandom, 1'($urandom), pick_coord(),
						pick_coord(), pick_coord(), $urandom, $urandom, $urandom));
					sent++;
				end
				1: begin
					send_item(mk(IDX_W'($urandom), 1'($urandom), $urandom, 1'($urandom),
						$urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
					sent++;
				end
				default: begin
					owner = pick_owner();
					ax = pick_coord();
					ay = pick_coord();
					az = pick_coord();
					len = $urandom_range(1, 8);
					drop_last = ($urandom_range(0, 7) == 0);
					for (int k = 0; k < len; k++) begin
						nidx = pick_neighbor(owner);
						send_item(mk(owner, 1'b1, {3'($urandom), nidx},
							(k == len - 1) && !drop_last, ax, ay, az,
							ax + pick_offset(), ay + pick_offset(), az + pick_offset()));
						sent++;
					end
				end
			endcase
		end
	endtask

	initial begin
		in_if.valid <= 1'b0;
		in_if.data  <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		cur_lc  = LOCAL_COUNT_RST;
		cur_tol = TOLERANCE_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every neighbor is a ghost, exact lexicographic order.
		send_item(mk(29'd0, 1'b1, 32'h0000_0001, 1'b0, '0, '0, '0, '0, '0, 32'd1));
		send_item(mk(29'd0, 1'b1, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, '0, '0, '1));
		send_item(mk(29'd0, 1'b1, 32'hE000_0002, 1'b0, 32'd5, 32'd5, 32'd5,
			32'd5, 32'd6, 32'd5));
		send_item(mk(29'd0, 1'b1, 32'h0000_0003, 1'b0, 32'd7, 32'd7, 32'd7,
			32'd7, 32'd7, 32'd7));
		send_item(mk(29'd0, 1'b1, 32'h0000_0004, 1'b0, 32'd8, '0, '0, 32'd7, '0, '0));
		send_item(mk(29'd0, 1'b1, 32'h1FFF_FFFF, 1'b1, C_MIN, C_MIN, C_MIN,
			C_MAX, C_MAX, C_MAX));
		send_item(mk(29'd1, 1'b0, 32'hDEAD_BEEF, 1'b0, C_MAX, '0, '0, '0, '0, '0));
		send_item(mk(29'd2, 1'b0, 32'hFFFF_FFFF, 1'b1, '0, '0, '0, '0, '0, '0));
		send_item(mk('1, 1'b1, 32'h0000_0000, 1'b1, C_MAX, C_MAX, C_MAX,
			C_MIN, C_MIN, C_MIN));

		set_config(1'b1, 1'b1, 1'b0, '0, TOLERANCE_RST, '0);
		send_item(mk(29'd3, 1'b1, 32'h10, 1'b0, '0, '0, '0, '1, 32'd656, -32'd655));
		send_item(mk(29'd3, 1'b1, 32'h11, 1'b0, '0, '0, '0, 32'd5, 32'd5, -32'd656));
		send_item(mk(29'd3, 1'b1, 32'h12, 1'b0, '0, '0, '0, '1, 32'd300, -32'd300));
		send_item(mk(29'd3, 1'b1, 32'h13, 1'b1, '0, '0, C_MIN, '0, '0, C_MAX));

		set_config(1'b0, 1'b0, 1'b1, 29'd4, TOLERANCE_RST, '0);
		send_item(mk(29'd3, 1'b1, 32'h4, 1'b0, 32'd1, 32'd2, 32'd3, 32'd1, 32'd2, 32'd3));
		send_item(mk(29'd3, 1'b1, 32'h4, 1'b0, 32'd1, 32'd2, 32'd3, 32'd1, 32'd2, 32'd4));
		send_item(mk(29'd4, 1'b1, 32'h4, 1'b0, '0, '0, '0, '0, '0, '0));
		send_item(mk(29'd4, 1'b1, 32'h3, 1'b1, '0, '0, '0, '0, '0, '0));

		set_config(1'b1, 1'b0, 1'b1, 29'd10, TOLERANCE_RST, '1);
		send_item(mk(29'd2, 1'b1, 32'h5, 1'b0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
		send_item(mk(29'd5, 1'b1, 32'h5, 1'b0, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9));
		send_item(mk(29'd6, 1'b1, 32'h5, 1'b1, '0, '0, '0, '0, '0, '0));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			lc_pick = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
				: IDX_W'($urandom_range(0, 200));
			case ($urandom_range(0, 4))
				0: tol_pick = '0;
				1: tol_pick = TOLERANCE_RST;
				2: tol_pick = '1;
				default: tol_pick = TOL_W'($urandom_range(0, 70000));
			endcase
			cut_pick = CUT_W'({32'($urandom_range(0, 3)), $urandom});
			case (p)
				0: set_config(1'b0, 1'b0, 1'b0, '0, '0, '0);
				1: set_config(1'b1, 1'b1, 1'b1, '1, '1, '1);
				default: set_config(p != 3, p[0], p[1], lc_pick, tol_pick, cut_pick);
			endcase
			random_phase(PHASE_ITEMS);
		end

		random_phase(24);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS half_neighbor_pair_filter");
		end else begin
			$display("FAIL half_neighbor_pair_filter");
		end
		$finish;
	end

endmodule
